### hdl/cqed_pkg.sv
package cqed_pkg;

    localparam int DataW = 32;
    localparam int CntW  = 5;

    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_REMOVE = 2'd1;
    localparam logic [1:0] MODE_DRAIN  = 2'd2;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_NONE  = 2'd3;

    localparam logic [CntW-1:0] CapReset = 5'd8;

    typedef enum logic {
        S_IDLE,
        S_POP
    } t_state;

    typedef struct packed {
        logic [1:0]              mode;
        logic signed [DataW-1:0] data;
    } t_in_item;

    typedef struct packed {
        logic [1:0]              status;
        logic signed [DataW-1:0] value;
        logic [CntW-1:0]         occupancy;
        logic                    is_empty;
        logic                    is_full;
    } t_out_item;

endpackage

### hdl/cqed_ram.sv
module cqed_ram
    import cqed_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [DataW-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [DataW-1:0] o_rdata
);

    logic [DataW-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

### hdl/circular_queue_with_even_drain.sv
// Insert, unused mode and commands on an empty queue give their result in the
//   output register in the next cycle after acceptance; remove and drain first
//   pop in S_POP, one slot RAM read per word, then load the output register.
// Throughput: one insert per cycle while the output is not stalled; the next
//   item waits for remove/drain to end. Reset (synchronous, active low) empties
//   the queue, sets capacity to 8 and clears output valid, not slot contents.
module circular_queue_with_even_drain
    import cqed_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  t_in_item        i_in,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output t_out_item       o_out,
    input  logic            i_cfg_valid,
    output logic            o_cfg_ready,
    input  logic [CntW-1:0] i_cfg_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [CntW-1:0] DepthCap = CntW'(DEPTH);

    t_state          r_state, n_state;
    logic [1:0]      r_mode, n_mode;
    logic [CntW-1:0] r_cap, n_cap;
    logic [CntW-1:0] r_rd_idx, n_rd_idx;
    logic [CntW-1:0] r_wr_idx, n_wr_idx;
    logic [CntW-1:0] r_cnt, n_cnt;
    logic            r_out_valid, n_out_valid;
    t_out_item       r_out, n_out;

    logic [CntW-1:0]  w_cap;
    logic [CntW-1:0]  w_rd_adv, w_wr_adv;
    logic             w_in_acc, w_cfg_acc;
    logic             w_we;
    logic [DataW-1:0] w_rdata;
    logic             w_load;
    logic [1:0]       w_status;
    logic [DataW-1:0] w_value;

    // capacity of 0 acts as 1, above DEPTH saturates
    always_comb begin
        priority if (r_cap == '0) begin
            w_cap = CntW'(1);
        end else if (int'(r_cap) > DEPTH) begin
            w_cap = DepthCap;
        end else begin
            w_cap = r_cap;
        end
    end

    assign w_rd_adv = ({1'b0, r_rd_idx} + 6'd1 >= {1'b0, w_cap}) ? '0 : r_rd_idx + 1'b1;
    assign w_wr_adv = ({1'b0, r_wr_idx} + 6'd1 >= {1'b0, w_cap}) ? '0 : r_wr_idx + 1'b1;

    assign o_in_ready  = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign o_cfg_ready = (r_state == S_IDLE);
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_cfg_acc   = i_cfg_valid && o_cfg_ready;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc && r_cnt != '0 &&
                    (i_in.mode == MODE_REMOVE || i_in.mode == MODE_DRAIN)) begin
                    n_state = S_POP;
                end
            end
            S_POP: begin
                if (r_mode == MODE_REMOVE || !w_rdata[0] || r_cnt == CntW'(1)) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and result
    always_comb begin
        n_mode   = r_mode;
        n_cap    = r_cap;
        n_rd_idx = r_rd_idx;
        n_wr_idx = r_wr_idx;
        n_cnt    = r_cnt;
        w_we     = 1'b0;
        w_load   = 1'b0;
        w_status = ST_DONE;
        w_value  = '0;

        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_mode = i_in.mode;
                    unique case (i_in.mode)
                        MODE_INSERT: begin
                            w_load = 1'b1;
                            if (r_cnt >= w_cap) begin
                                w_status = ST_FULL;
                            end else begin
                                w_we     = 1'b1;
                                n_wr_idx = w_wr_adv;
                                n_cnt    = r_cnt + 1'b1;
                            end
                        end
                        MODE_REMOVE, MODE_DRAIN: begin
                            if (r_cnt == '0) begin
                                w_load   = 1'b1;
                                w_status = ST_EMPTY;
                            end
                        end
                        default: w_load = 1'b1;
                    endcase
                end
            end
            S_POP: begin
                n_rd_idx = w_rd_adv;
                n_cnt    = r_cnt - 1'b1;
                priority if (r_mode == MODE_REMOVE || !w_rdata[0]) begin
                    w_load  = 1'b1;
                    w_value = w_rdata;
                end else if (r_cnt == CntW'(1)) begin
                    w_load   = 1'b1;
                    w_status = ST_NONE;
                end else begin
                    // odd word with more left: keep popping
                    w_load = 1'b0;
                end
            end
            default: ;
        endcase

        // capacity write also empties the queue
        if (w_cfg_acc) begin
            n_cap    = i_cfg_data;
            n_rd_idx = '0;
            n_wr_idx = '0;
            n_cnt    = '0;
        end

        n_out_valid     = w_load || (r_out_valid && !i_out_ready);
        n_out           = r_out;
        if (w_load) begin
            n_out.status    = w_status;
            n_out.value     = w_value;
            n_out.occupancy = n_cnt;
            n_out.is_empty  = (n_cnt == '0);
            n_out.is_full   = (n_cnt >= w_cap);
        end
    end

    // read is issued every cycle at the next head, so data lines up with S_POP
    cqed_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (AW'(r_wr_idx)),
        .i_wdata (i_in.data),
        .i_raddr (AW'(n_rd_idx)),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cap       <= CapReset;
            r_rd_idx    <= '0;
            r_wr_idx    <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cap       <= n_cap;
            r_rd_idx    <= n_rd_idx;
            r_wr_idx    <= n_wr_idx;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode <= n_mode;
        r_out  <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

### hdl/cqed_checker.sv
module cqed_checker
    import cqed_pkg::*;
(
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            o_in_ready,
    input logic            o_out_valid,
    input logic            i_out_ready,
    input t_out_item       o_out,
    input logic            o_cfg_ready
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("result changed while stalled");

    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out.is_empty == (o_out.occupancy == '0)))
        else $error("empty flag disagrees with occupancy");

    a_refused: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.status == ST_FULL |-> o_out.is_full && o_out.value == '0)
        else $error("refused insert without full queue");

    a_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out.status == ST_EMPTY || o_out.status == ST_NONE)
        |-> o_out.is_empty && o_out.value == '0)
        else $error("empty or exhausted result with words left");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready && o_cfg_ready)
        else $error("block not idle after reset");

endmodule

bind circular_queue_with_even_drain cqed_checker u_cqed_checker (.*);

### tb/testbench.sv
`timescale 1ns / 1ps

import cqed_pkg::*;

class queue_tracker;
    localparam int SlotCount = 16;

    logic [DataW-1:0] slots [SlotCount];
    int unsigned      head;
    int unsigned      tail;
    int unsigned      held;
    logic [CntW-1:0]  cap_reg;
    t_out_item        expected_results [$];
    int               errors;

    function new();
        head    = 0;
        tail    = 0;
        held    = 0;
        cap_reg = CapReset;
        errors  = 0;
    endfunction

    // 0 acts as 1, anything past the built depth saturates
    function int unsigned usable();
        if (cap_reg == 0)
            return 1;
        if (cap_reg > SlotCount)
            return SlotCount;
        return int'(cap_reg);
    endfunction

    function int unsigned next_slot(int unsigned idx);
        return (idx + 1 >= usable()) ? 0 : idx + 1;
    endfunction

    function logic [DataW-1:0] take_oldest();
        logic [DataW-1:0] w;
        w    = slots[head];
        head = next_slot(head);
        held--;
        return w;
    endfunction

    function void write_capacity(logic [CntW-1:0] v);
        cap_reg = v;
        head    = 0;
        tail    = 0;
        held    = 0;
    endfunction

    function void note_command(t_in_item c);
        t_out_item        r;
        logic [DataW-1:0] w;
        bit               found;
        r     = '0;
        found = 0;
        case (c.mode)
            MODE_INSERT: begin
                if (held >= usable()) begin
                    r.status = ST_FULL;
                end else begin
                    slots[tail] = c.data;
                    tail = next_slot(tail);
                    held++;
                end
            end
            MODE_REMOVE: begin
                if (held == 0)
                    r.status = ST_EMPTY;
                else
                    r.value = take_oldest();
            end
            MODE_DRAIN: begin
                if (held == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    while (held > 0 && !found) begin
                        w = take_oldest();
                        if (!w[0]) begin
                            found   = 1;
                            r.value = w;
                        end
                    end
                    if (!found)
                        r.status = ST_NONE;
                end
            end
            default: begin
                // unused mode leaves the queue alone
            end
        endcase
        r.occupancy = CntW'(held);
        r.is_empty  = (held == 0);
        r.is_full   = (held >= usable());
        expected_results.push_back(r);
    endfunction

    function void check_result(t_out_item got);
        t_out_item want;
        if (expected_results.size() == 0) begin
            $error("result with nothing expected: status %0d value %0d", got.status,
                   got.value);
            errors++;
            return;
        end
        want = expected_results.pop_front();
        if (got.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, got.status);
            errors++;
        end
        if (got.value !== want.value) begin
            $error("value: expected %0d, actual %0d", want.value, got.value);
            errors++;
        end
        if (got.occupancy !== want.occupancy) begin
            $error("occupancy: expected %0d, actual %0d", want.occupancy, got.occupancy);
            errors++;
        end
        if (got.is_empty !== want.is_empty) begin
            $error("is_empty: expected %0d, actual %0d", want.is_empty, got.is_empty);
            errors++;
        end
        if (got.is_full !== want.is_full) begin
            $error("is_full: expected %0d, actual %0d", want.is_full, got.is_full);
            errors++;
        end
    endfunction
endclass

module testbench;
    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int         PhaseItems  = 130;
    localparam int         HoldCycles  = 300;

    logic            i_clk       = 1'b0;
    logic            i_rst_n     = 1'b0;
    logic            i_in_valid  = 1'b0;
    t_in_item        i_in        = '0;
    logic            i_out_ready = 1'b0;
    logic            i_cfg_valid = 1'b0;
    logic [CntW-1:0] i_cfg_data  = '0;
    logic            o_in_ready;
    logic            o_out_valid;
    t_out_item       o_out;
    logic            o_cfg_ready;

    queue_tracker tracker = new();
    int           commands_sent = 0;
    int           hold_requests = 0;

    circular_queue_with_even_drain #(
        .DEPTH(16)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in       (i_in),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out      (o_out),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // all drives are nonblocking, so values seen here are the pre-edge ones
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready)
                tracker.check_result(o_out);
            if (i_cfg_valid && o_cfg_ready)
                tracker.write_capacity(i_cfg_data);
            if (i_in_valid && o_in_ready)
                tracker.note_command(i_in);
        end
    end

    // receiver: shifting stall styles, plus a long hold-off on request
    initial begin
        int style;
        int left;
        int holds_done;
        style      = 0;
        left       = 0;
        holds_done = 0;
        forever begin
            @(posedge i_clk);
            if (hold_requests != holds_done) begin
                holds_done = hold_requests;
                i_out_ready <= 1'b0;
                repeat (HoldCycles) @(posedge i_clk);
            end else begin
                if (left == 0) begin
                    style = $urandom_range(0, 3);
                    left  = $urandom_range(20, 120);
                end
                left--;
                case (style)
                    0: i_out_ready <= 1'b1;
                    1: i_out_ready <= 1'($urandom_range(0, 1));
                    2: i_out_ready <= (left % 3 == 0);
                    default: i_out_ready <= ($urandom_range(0, 4) == 0);
                endcase
            end
        end
    end

    initial begin
        #5_000_000;
        $display("testbench: errors");
        $finish;
    end

    function automatic t_in_item make_cmd(logic [1:0] m, logic [DataW-1:0] d);
        t_in_item c;
        c.mode = m;
        c.data = d;
        return c;
    endfunction

    function automatic t_in_item random_command(int insert_pct, int odd_pct);
        t_in_item c;
        int       pick;
        c.data = $urandom();
        pick   = $urandom_range(0, 9);
        if ($urandom_range(0, 99) < insert_pct)
            c.mode = MODE_INSERT;
        else if (pick < 5)
            c.mode = MODE_REMOVE;
        else if (pick < 9)
            c.mode = MODE_DRAIN;
        else
            c.mode = MODE_UNUSED;
        case ($urandom_range(0, 15))
            0: c.data = 32'h7FFF_FFFF;
            1: c.data = 32'h8000_0000;
            2: c.data = '0;
            3: c.data = '1;
            default: ;
        endcase
        if ($urandom_range(0, 99) < odd_pct)
            c.data[0] = 1'b1;
        return c;
    endfunction

    // leaves valid high; the caller lowers it when a gap follows
    task automatic send_command(t_in_item c);
        i_in_valid <= 1'b1;
        i_in       <= c;
        do
            @(posedge i_clk);
        while (!o_in_ready);
        if (c.mode != MODE_UNUSED)
            commands_sent++;
    endtask

    task automatic send_burst(int n, int insert_pct, int odd_pct);
        int gap;
        repeat (n) send_command(random_command(insert_pct, odd_pct));
        gap = $urandom_range(0, 5);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic settle_queue();
        int guard;
        guard = 0;
        i_in_valid <= 1'b0;
        do begin
            @(posedge i_clk);
            guard++;
        end while (tracker.expected_results.size() != 0 && guard < 50_000);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic set_capacity(logic [CntW-1:0] v);
        settle_queue();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do
            @(posedge i_clk);
        while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin
        logic [CntW-1:0] caps [8];
        int              start;
        int              insert_pct;
        caps = '{5'd16, 5'd31, 5'd3, 5'd0, 5'd1, 5'd8, 5'd16, 5'd12};
        caps[7] = CntW'($urandom_range(2, 15));

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset capacity of 8; empty-queue cases first
        send_command(make_cmd(MODE_REMOVE, 32'd0));
        send_command(make_cmd(MODE_DRAIN, 32'd0));
        send_command(make_cmd(MODE_UNUSED, 32'h0000_5A5A));
        send_command(make_cmd(MODE_INSERT, 32'h7FFF_FFFF));
        send_command(make_cmd(MODE_INSERT, 32'h8000_0000));
        send_command(make_cmd(MODE_INSERT, 32'hFFFF_FFFF));
        send_command(make_cmd(MODE_INSERT, 32'hFFFF_FFFE));
        send_command(make_cmd(MODE_INSERT, 32'd0));
        send_command(make_cmd(MODE_DRAIN, 32'd0));  // skips max positive, finds min negative
        send_command(make_cmd(MODE_REMOVE, 32'd0));
        send_command(make_cmd(MODE_DRAIN, 32'd0));  // negative even word
        send_command(make_cmd(MODE_DRAIN, 32'd0));
        send_command(make_cmd(MODE_INSERT, 32'd1));
        send_command(make_cmd(MODE_INSERT, 32'd3));
        send_command(make_cmd(MODE_DRAIN, 32'd0));  // nothing even: empties the queue
        send_command(make_cmd(MODE_UNUSED, 32'hFFFF_FFFF));

        set_capacity(5'd1);
        send_command(make_cmd(MODE_INSERT, 32'd6));
        send_command(make_cmd(MODE_INSERT, 32'd7));  // refused, full
        send_command(make_cmd(MODE_REMOVE, 32'd0));
        send_command(make_cmd(MODE_REMOVE, 32'd0));

        // zero capacity behaves as one slot
        set_capacity(5'd0);
        send_command(make_cmd(MODE_INSERT, 32'd5));
        send_command(make_cmd(MODE_INSERT, 32'd9));
        send_command(make_cmd(MODE_DRAIN, 32'd0));

        for (int phase = 0; phase < 8; phase++) begin
            set_capacity(caps[phase]);
            start = commands_sent;
            if (phase == 0)
                hold_requests++;
            while (commands_sent - start < PhaseItems) begin
                // fill hard while the receiver is held off
                if (phase == 0 && commands_sent - start < 40)
                    insert_pct = 85;
                else
                    insert_pct = $urandom_range(20, 80);
                case ($urandom_range(0, 2))
                    0: send_burst($urandom_range(1, 24), insert_pct, 10);
                    1: send_burst($urandom_range(1, 24), insert_pct, 50);
                    default: send_burst($urandom_range(1, 24), insert_pct, 90);
                endcase
            end
        end

        settle_queue();
        if (tracker.expected_results.size() != 0) begin
            $error("%0d expected results never arrived", tracker.expected_results.size());
            tracker.errors++;
        end
        if (tracker.errors == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end
endmodule
